### rtl/mfce_pkg.sv
// ---------------------------------------------------------------------------
// mfce_pkg: shared types and constants of the management frame channel
// extractor.
// Holds the parse phase, element kind and status codes, and the structs that
// carry one frame byte and one result between the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mfce_pkg;

    // Fixed parameter bytes of beacon and probe response frames.
    localparam int unsigned FIXED_PARAM_BYTES = 12;
    // Fixed parameter bytes of association request frames.
    localparam int unsigned ASSOC_PARAM_BYTES = 4;

    // Frame type and subtype codes from frame control byte 0.
    localparam logic [1:0] TYPE_MGMT       = 2'd0;
    localparam logic [3:0] SUB_ASSOC_REQ   = 4'd0;
    localparam logic [3:0] SUB_PROBE_REQ   = 4'd4;
    localparam logic [3:0] SUB_PROBE_RESP  = 4'd5;
    localparam logic [3:0] SUB_BEACON      = 4'd8;

    // Tagged element ids of interest.
    localparam logic [7:0] EID_DS_PARAM = 8'd3;
    localparam logic [7:0] EID_HT_INFO  = 8'd61;

    // Valid channel ranges.
    localparam logic [7:0] DS_CHAN_MIN = 8'd1;
    localparam logic [7:0] DS_CHAN_MAX = 8'd13;
    localparam logic [7:0] HT_CHAN_MIN = 8'd34;
    localparam logic [7:0] HT_CHAN_MAX = 8'd165;

    // Byte position saturates at this value.
    localparam logic [5:0] POS_MAX = 6'd63;

    typedef enum logic [2:0] {
        PH_FC    = 3'd0,
        PH_PRE   = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_SKIP  = 3'd4,
        PH_VALUE = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DS   = 2'd1,
        KIND_HT   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_UNSUPPORTED = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_FOUND       = 2'd2
    } status_t;

    // One frame byte as held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] frame_byte;
        logic       last_byte;
    } item_t;

    // One result transaction.
    typedef struct packed {
        status_t    status;
        logic [7:0] channel;
    } result_t;

endpackage

`default_nettype wire

### rtl/mfce_in_reg.sv
// ---------------------------------------------------------------------------
// mfce_in_reg: input register of the channel extractor.
// Captures one frame byte per transaction and holds it until the parser
// consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mfce_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           frame_valid,
    input  wire logic [7:0]     frame_byte,
    input  wire logic           last_byte,
    input  wire logic           consume,
    output logic                frame_stall,
    output mfce_pkg::item_t     item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       accept;

    // The register is free when empty or when its byte leaves this cycle.
    assign frame_stall = valid_reg & ~consume;
    assign accept      = frame_valid & ~frame_stall;
    assign valid_next  = accept | (valid_reg & ~consume);

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= frame_byte;
            last_reg <= last_byte;
        end
    end

    assign item.valid      = valid_reg;
    assign item.frame_byte = byte_reg;
    assign item.last_byte  = last_reg;

    // The parser never consumes an empty register.
    assert property (@(posedge clk) disable iff (!rst_n) consume |-> valid_reg)
        else $error("mfce_in_reg: consume while empty");
    // A stall is only raised while a byte is held.
    assert property (@(posedge clk) disable iff (!rst_n) frame_stall |=> valid_reg)
        else $error("mfce_in_reg: held byte lost during stall");
    // A byte accepted into an empty register is present next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !valid_reg) |=> valid_reg)
        else $error("mfce_in_reg: accepted byte not registered");

endmodule

`default_nettype wire

### rtl/mfce_parser.sv
// ---------------------------------------------------------------------------
// mfce_parser: tagged element walker of the channel extractor.
// Tracks the byte position and parse phase of the current frame and forms
// the status and channel reported on its last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module mfce_parser #(
    parameter int unsigned HEADER_BYTES = 24
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire mfce_pkg::item_t item,
    output mfce_pkg::result_t   result
);

    // Element offsets per subtype.
    localparam logic [5:0] OFF_LONG  =
        6'(HEADER_BYTES + mfce_pkg::FIXED_PARAM_BYTES);
    localparam logic [5:0] OFF_ASSOC =
        6'(HEADER_BYTES + mfce_pkg::ASSOC_PARAM_BYTES);
    localparam logic [5:0] OFF_PROBE = 6'(HEADER_BYTES);

    logic [5:0]        pos_reg,     pos_next;
    logic [5:0]        estart_reg,  estart_next;
    mfce_pkg::phase_t  phase_reg,   phase_next;
    mfce_pkg::kind_t   kind_reg,    kind_next;
    logic [7:0]        skip_reg,    skip_next;
    mfce_pkg::status_t hstat_reg,   hstat_next;
    logic [7:0]        hchan_reg,   hchan_next;

    logic [7:0] b;
    logic [1:0] fc_type;
    logic [3:0] fc_sub;
    logic [6:0] pos_plus1;
    logic [7:0] skip_dec;
    logic       chan_good;
    logic [5:0] walk_pos;

    assign b         = item.frame_byte;
    assign fc_type   = b[3:2];
    assign fc_sub    = b[7:4];
    assign pos_plus1 = {1'b0, pos_reg} + 7'd1;
    assign skip_dec  = skip_reg - 8'd1;
    assign walk_pos  = (pos_reg == mfce_pkg::POS_MAX) ? pos_reg : pos_plus1[5:0];

    // Range check of the candidate channel byte.
    always_comb
    begin
        if (kind_reg == mfce_pkg::KIND_DS)
        begin
            chan_good = (b >= mfce_pkg::DS_CHAN_MIN) && (b <= mfce_pkg::DS_CHAN_MAX);
        end
        else
        begin
            chan_good = (b >= mfce_pkg::HT_CHAN_MIN) && (b <= mfce_pkg::HT_CHAN_MAX);
        end
    end

    // Next state of the element walk for the byte being consumed.
    always_comb
    begin
        estart_next = estart_reg;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        skip_next   = skip_reg;
        hstat_next  = hstat_reg;
        hchan_next  = hchan_reg;
        case (phase_reg)
            mfce_pkg::PH_FC:
            begin
                phase_next = mfce_pkg::PH_PRE;
                if (fc_type != mfce_pkg::TYPE_MGMT)
                begin
                    hstat_next = mfce_pkg::ST_UNSUPPORTED;
                    hchan_next = 8'd0;
                    phase_next = mfce_pkg::PH_DONE;
                end
                else if (fc_sub == mfce_pkg::SUB_BEACON
                         || fc_sub == mfce_pkg::SUB_PROBE_RESP)
                begin
                    estart_next = OFF_LONG;
                end
                else if (fc_sub == mfce_pkg::SUB_ASSOC_REQ)
                begin
                    estart_next = OFF_ASSOC;
                end
                else if (fc_sub == mfce_pkg::SUB_PROBE_REQ)
                begin
                    estart_next = OFF_PROBE;
                end
                else
                begin
                    hstat_next = mfce_pkg::ST_UNSUPPORTED;
                    hchan_next = 8'd0;
                    phase_next = mfce_pkg::PH_DONE;
                end
            end
            mfce_pkg::PH_PRE:
            begin
                if (pos_plus1 >= {1'b0, estart_reg})
                begin
                    phase_next = mfce_pkg::PH_ID;
                end
            end
            mfce_pkg::PH_ID:
            begin
                if (b == mfce_pkg::EID_DS_PARAM)
                begin
                    kind_next = mfce_pkg::KIND_DS;
                end
                else if (b == mfce_pkg::EID_HT_INFO)
                begin
                    kind_next = mfce_pkg::KIND_HT;
                end
                else
                begin
                    kind_next = mfce_pkg::KIND_NONE;
                end
                phase_next = mfce_pkg::PH_LEN;
            end
            mfce_pkg::PH_LEN:
            begin
                if (kind_reg != mfce_pkg::KIND_NONE)
                begin
                    phase_next = mfce_pkg::PH_VALUE;
                end
                else if (b == 8'd0)
                begin
                    phase_next = mfce_pkg::PH_ID;
                end
                else
                begin
                    skip_next  = b;
                    phase_next = mfce_pkg::PH_SKIP;
                end
            end
            mfce_pkg::PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    phase_next = mfce_pkg::PH_ID;
                end
            end
            mfce_pkg::PH_VALUE:
            begin
                hstat_next = chan_good ? mfce_pkg::ST_FOUND : mfce_pkg::ST_NOT_FOUND;
                hchan_next = chan_good ? b : 8'd0;
                phase_next = mfce_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = mfce_pkg::PH_DONE;
            end
        endcase
        pos_next = walk_pos;
    end

    // Result of the frame as it stands after this byte.
    assign result.status  = hstat_next;
    assign result.channel = hchan_next;

    // Walk state; a last byte starts the next frame over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 6'd0;
            estart_reg <= 6'd0;
            phase_reg  <= mfce_pkg::PH_FC;
            kind_reg   <= mfce_pkg::KIND_NONE;
            skip_reg   <= 8'd0;
            hstat_reg  <= mfce_pkg::ST_NOT_FOUND;
            hchan_reg  <= 8'd0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg    <= 6'd0;
                estart_reg <= 6'd0;
                phase_reg  <= mfce_pkg::PH_FC;
                kind_reg   <= mfce_pkg::KIND_NONE;
                skip_reg   <= 8'd0;
                hstat_reg  <= mfce_pkg::ST_NOT_FOUND;
                hchan_reg  <= 8'd0;
            end
            else
            begin
                pos_reg    <= pos_next;
                estart_reg <= estart_next;
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                skip_reg   <= skip_next;
                hstat_reg  <= hstat_next;
                hchan_reg  <= hchan_next;
            end
        end
    end

    // Waiting for the element offset implies an offset was set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mfce_pkg::PH_PRE) |-> (estart_reg >= 6'd2))
        else $error("mfce_parser: element offset missing");
    // Skipping always has body bytes left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mfce_pkg::PH_SKIP) |-> (skip_reg != 8'd0))
        else $error("mfce_parser: skip with zero count");
    // A channel byte is only awaited for a matched element.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mfce_pkg::PH_VALUE) |-> (kind_reg != mfce_pkg::KIND_NONE))
        else $error("mfce_parser: value phase without element kind");
    // A found channel is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hstat_reg == mfce_pkg::ST_FOUND) |-> (hchan_reg != 8'd0))
        else $error("mfce_parser: found status with zero channel");

endmodule

`default_nettype wire

### rtl/mgmt_frame_channel_extractor_core.sv
// ---------------------------------------------------------------------------
// mgmt_frame_channel_extractor_core: management frame channel extractor.
// Walks the tagged elements of a management frame, one byte per transaction,
// and reports the DS or HT channel it announces on the frame's last byte.
// ---------------------------------------------------------------------------
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+---------------------------------
//  frame    | frame_valid / frame_stall   | frame_byte[7:0], last_byte
//  result   | result_valid / result_stall | status[1:0], channel[7:0]
//
//  One frame byte enters per cycle while frame_stall is low; a result is
//  presented from the result register once the parser takes its last byte.
//  Only a last byte waits on the result register; other bytes never stall.
//  Reset clears the handshake and walk state and returns to frame control.
//  While a result is stalled, bytes keep flowing until the next last byte
//  reaches the input register, which then stalls the frame channel.
// ---------------------------------------------------------------------------
`default_nettype none

module mgmt_frame_channel_extractor_core #(
    parameter int unsigned HEADER_BYTES = 24
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       frame_valid,
    output logic            frame_stall,
    input  wire logic [7:0] frame_byte,
    input  wire logic       last_byte,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [1:0]      status,
    output logic [7:0]      channel
);

    mfce_pkg::item_t   item;
    mfce_pkg::result_t walk_result;
    logic              consume;
    logic              res_valid_reg;
    logic              res_valid_next;
    mfce_pkg::result_t res_reg;
    logic              load;

    // A held byte moves on unless it is a last byte facing a full, stalled output.
    assign consume = item.valid
                   & (~item.last_byte | ~res_valid_reg | ~result_stall);
    assign load    = consume & item.last_byte;

    mfce_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte),
        .consume     (consume),
        .frame_stall (frame_stall),
        .item        (item)
    );

    mfce_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (consume),
        .item   (item),
        .result (walk_result)
    );

    // Result register occupancy.
    always_comb
    begin
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= walk_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = res_reg.status;
    assign channel      = res_reg.channel;

    // A result is never overwritten while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_stall) |-> !load)
        else $error("core: result overwritten while stalled");
    // A loaded result is presented next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) load |=> res_valid_reg)
        else $error("core: loaded result not presented");
    // Only a held last byte can back up the frame channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (item.last_byte && res_valid_reg && result_stall))
        else $error("core: unexpected frame stall");

endmodule

`default_nettype wire

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the management frame channel extractor.
// Sends 802.11 frames one byte per transaction and predicts the status and
// channel report of every frame with a cycle-free model of the element walk.
// Each report is checked field by field against the oldest prediction.
// Directed frames cover frame control decoding, channel range limits,
// zero-length elements, early frame ends and long frames. A long result
// hold-off and random traffic under several idle and stall mixes follow.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int unsigned HDR_BYTES       = 24;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned RANDOM_BYTES    = 140;

    // Clock, reset and block ports.
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       frame_valid  = 1'b0;
    logic       frame_stall;
    logic [7:0] frame_byte   = 8'd0;
    logic       last_byte    = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] channel;

    // Traffic shaping knobs, read at each clock.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_off_cycles    = 0;

    // Run statistics and failure count.
    int unsigned mismatches   = 0;
    int unsigned frames_sent  = 0;
    int unsigned bytes_taken  = 0;
    int unsigned found_seen   = 0;
    int unsigned missing_seen = 0;
    int unsigned unsupp_seen  = 0;

    // Bytes of the frame under construction.
    logic [7:0] frame_buf[$];

    // Supported management subtypes.
    logic [3:0] mgmt_subs[4] = '{mfce_pkg::SUB_ASSOC_REQ, mfce_pkg::SUB_PROBE_REQ,
                                 mfce_pkg::SUB_PROBE_RESP, mfce_pkg::SUB_BEACON};

    // State of the channel walk model.
    logic [5:0]        walk_pos;
    logic [5:0]        walk_elem_start;
    mfce_pkg::phase_t  walk_phase;
    mfce_pkg::kind_t   walk_kind;
    logic [7:0]        walk_skip;
    mfce_pkg::status_t walk_status;
    logic [7:0]        walk_channel;
    mfce_pkg::result_t channel_reports[$];

    mgmt_frame_channel_extractor_core #(
        .HEADER_BYTES (HDR_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .channel      (channel)
    );

    always #1 clk = ~clk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Returns the walk model to the start of a new frame.
    task automatic restart_walk();
        walk_pos        = '0;
        walk_elem_start = '0;
        walk_phase      = mfce_pkg::PH_FC;
        walk_kind       = mfce_pkg::KIND_NONE;
        walk_skip       = '0;
        walk_status     = mfce_pkg::ST_NOT_FOUND;
        walk_channel    = '0;
    endtask

    // Advances the walk model by one accepted frame byte.
    task automatic walk_frame_byte(input logic [7:0] b, input logic last);
        mfce_pkg::result_t rep;
        int unsigned       offset;
        logic              ok;
        logic              good;
        offset = 0;
        ok     = 1'b1;
        case (walk_phase)
            mfce_pkg::PH_FC:
            begin
                // Only four management subtypes carry elements we parse.
                if (b[3:2] != mfce_pkg::TYPE_MGMT)
                    ok = 1'b0;
                else if (b[7:4] == mfce_pkg::SUB_BEACON || b[7:4] == mfce_pkg::SUB_PROBE_RESP)
                    offset = HDR_BYTES + mfce_pkg::FIXED_PARAM_BYTES;
                else if (b[7:4] == mfce_pkg::SUB_ASSOC_REQ)
                    offset = HDR_BYTES + mfce_pkg::ASSOC_PARAM_BYTES;
                else if (b[7:4] == mfce_pkg::SUB_PROBE_REQ)
                    offset = HDR_BYTES;
                else
                    ok = 1'b0;
                if (!ok)
                begin
                    walk_status  = mfce_pkg::ST_UNSUPPORTED;
                    walk_channel = '0;
                    walk_phase   = mfce_pkg::PH_DONE;
                end
                else
                begin
                    walk_elem_start = (offset > 63) ? mfce_pkg::POS_MAX : offset[5:0];
                    walk_phase      = (walk_elem_start <= 1) ? mfce_pkg::PH_ID
                                                             : mfce_pkg::PH_PRE;
                end
            end
            mfce_pkg::PH_PRE:
            begin
                if (int'(walk_pos) + 1 >= int'(walk_elem_start))
                    walk_phase = mfce_pkg::PH_ID;
            end
            mfce_pkg::PH_ID:
            begin
                if (b == mfce_pkg::EID_DS_PARAM)
                    walk_kind = mfce_pkg::KIND_DS;
                else if (b == mfce_pkg::EID_HT_INFO)
                    walk_kind = mfce_pkg::KIND_HT;
                else
                    walk_kind = mfce_pkg::KIND_NONE;
                walk_phase = mfce_pkg::PH_LEN;
            end
            mfce_pkg::PH_LEN:
            begin
                if (walk_kind != mfce_pkg::KIND_NONE)
                    walk_phase = mfce_pkg::PH_VALUE;
                else if (b == 8'd0)
                    walk_phase = mfce_pkg::PH_ID;
                else
                begin
                    walk_skip  = b;
                    walk_phase = mfce_pkg::PH_SKIP;
                end
            end
            mfce_pkg::PH_SKIP:
            begin
                walk_skip = walk_skip - 8'd1;
                if (walk_skip == 8'd0)
                    walk_phase = mfce_pkg::PH_ID;
            end
            mfce_pkg::PH_VALUE:
            begin
                // The byte after the length byte is the channel, whatever the length.
                if (walk_kind == mfce_pkg::KIND_DS)
                    good = (b >= mfce_pkg::DS_CHAN_MIN && b <= mfce_pkg::DS_CHAN_MAX);
                else
                    good = (b >= mfce_pkg::HT_CHAN_MIN && b <= mfce_pkg::HT_CHAN_MAX);
                walk_status  = good ? mfce_pkg::ST_FOUND : mfce_pkg::ST_NOT_FOUND;
                walk_channel = good ? b : 8'd0;
                walk_phase   = mfce_pkg::PH_DONE;
            end
            default:
            begin
                walk_phase = mfce_pkg::PH_DONE;
            end
        endcase
        walk_pos = (walk_pos == mfce_pkg::POS_MAX) ? mfce_pkg::POS_MAX : walk_pos + 6'd1;
        if (last)
        begin
            rep.status  = walk_status;
            rep.channel = walk_channel;
            channel_reports.push_back(rep);
            restart_walk();
        end
    endtask

    // Compares one report transaction with the oldest prediction.
    task automatic check_report(input logic [1:0] st, input logic [7:0] ch);
        mfce_pkg::result_t want;
        if (channel_reports.size() == 0)
        begin
            report_mismatch($sformatf("report status %0d channel %0d with no frame pending",
                                      st, ch));
            return;
        end
        want = channel_reports.pop_front();
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        if (ch !== want.channel)
            report_mismatch($sformatf("channel %0d, expected %0d", ch, want.channel));
        case (want.status)
            mfce_pkg::ST_FOUND:     found_seen++;
            mfce_pkg::ST_NOT_FOUND: missing_seen++;
            default:                unsupp_seen++;
        endcase
    endtask

    // Predicts on every byte transaction and checks every report transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
            begin
                walk_frame_byte(frame_byte, last_byte);
                bytes_taken++;
            end
            if (result_valid && !result_stall)
                check_report(status, channel);
        end
    end

    // Receiver: a counted hold-off first, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_stall    <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Offers one byte, with random idle cycles ahead of it, until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            frame_valid <= 1'b0;
            frame_byte  <= 8'($urandom_range(0, 255));
            last_byte   <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte  <= b;
        last_byte   <= last;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
    endtask

    // Sends the first keep bytes of the built frame, marking the final one.
    task automatic send_frame(input int unsigned keep);
        for (int unsigned i = 0; i < keep; i++)
            send_byte(frame_buf[i], i == keep - 1);
        frames_sent++;
    endtask

    // Starts a management frame: frame control and header padding up to the elements.
    task automatic begin_frame(input logic [3:0] sub);
        logic [1:0]  proto;
        int unsigned offset;
        proto = 2'($urandom_range(0, 3));
        if (sub == mfce_pkg::SUB_BEACON || sub == mfce_pkg::SUB_PROBE_RESP)
            offset = HDR_BYTES + mfce_pkg::FIXED_PARAM_BYTES;
        else if (sub == mfce_pkg::SUB_ASSOC_REQ)
            offset = HDR_BYTES + mfce_pkg::ASSOC_PARAM_BYTES;
        else
            offset = HDR_BYTES;
        frame_buf = {};
        frame_buf.push_back({sub, mfce_pkg::TYPE_MGMT, proto});
        while (frame_buf.size() < offset)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Appends an element with random body bytes.
    task automatic add_element(input logic [7:0] id, input logic [7:0] len);
        frame_buf.push_back(id);
        frame_buf.push_back(len);
        repeat (len)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Appends a DS or HT element whose first body byte is the channel.
    task automatic add_channel_element(input logic [7:0] id, input logic [7:0] len,
                                       input logic [7:0] chan);
        frame_buf.push_back(id);
        frame_buf.push_back(len);
        if (len > 0)
        begin
            frame_buf.push_back(chan);
            repeat (len - 1)
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Random element id that is neither DS parameter nor HT information.
    function automatic logic [7:0] filler_id();
        logic [7:0] id;
        do
            id = 8'($urandom_range(0, 255));
        while (id == mfce_pkg::EID_DS_PARAM || id == mfce_pkg::EID_HT_INFO);
        return id;
    endfunction

    // Builds and sends one random frame: mostly well formed, some foreign or noise.
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned keep;
        logic [7:0]  id;
        logic [7:0]  chan;
        logic [3:0]  sub;
        logic [1:0]  ftype;
        logic [1:0]  proto;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            begin_frame(mgmt_subs[2'($urandom_range(0, 3))]);
            repeat ($urandom_range(0, 3))
                add_element(filler_id(), 8'($urandom_range(0, 5)));
            if ($urandom_range(0, 99) < 85)
            begin
                id = $urandom_range(0, 1) ? mfce_pkg::EID_DS_PARAM : mfce_pkg::EID_HT_INFO;
                if ($urandom_range(0, 99) < 65)
                    chan = (id == mfce_pkg::EID_DS_PARAM) ? 8'($urandom_range(1, 13))
                                                          : 8'($urandom_range(34, 165));
                else
                    chan = 8'($urandom_range(0, 255));
                add_channel_element(id,
                                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                                : 8'd1,
                                    chan);
            end
            repeat ($urandom_range(0, 2))
                add_element(8'($urandom_range(0, 255)), 8'($urandom_range(0, 5)));
        end
        else if (pick < 85)
        begin
            // Frame of a type or subtype the block does not parse.
            do
            begin
                sub   = 4'($urandom_range(0, 15));
                ftype = 2'($urandom_range(0, 3));
            end
            while (ftype == mfce_pkg::TYPE_MGMT &&
                   (sub == mfce_pkg::SUB_ASSOC_REQ || sub == mfce_pkg::SUB_PROBE_REQ ||
                    sub == mfce_pkg::SUB_PROBE_RESP || sub == mfce_pkg::SUB_BEACON));
            proto     = 2'($urandom_range(0, 3));
            frame_buf = {};
            frame_buf.push_back({sub, ftype, proto});
            repeat ($urandom_range(0, 6))
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Pure noise, long enough at times to saturate the byte position.
            frame_buf = {};
            repeat ($urandom_range(1, 80))
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        keep = frame_buf.size();
        if ($urandom_range(0, 99) < 15)
            keep = $urandom_range(1, keep);
        send_frame(keep);
    endtask

    // One-byte frames over every subtype and frame type.
    task automatic test_frame_control_only();
        logic [1:0] proto;
        for (int s = 0; s < 16; s++)
        begin
            proto     = (s == 0) ? 2'd0 : 2'($urandom_range(0, 3));
            frame_buf = {};
            frame_buf.push_back({4'(s), mfce_pkg::TYPE_MGMT, proto});
            send_frame(1);
        end
        for (int t = 1; t < 4; t++)
        begin
            frame_buf = {};
            frame_buf.push_back({4'hF, 2'(t), 2'b11});
            send_frame(1);
        end
    endtask

    // DS and HT channels at and just past each end of their ranges.
    task automatic test_channel_ranges();
        logic [7:0] ds_vals[5] = '{8'd0, 8'd1, 8'd13, 8'd14, 8'd255};
        logic [7:0] ht_vals[5] = '{8'd33, 8'd34, 8'd165, 8'd166, 8'd0};
        for (int i = 0; i < 5; i++)
        begin
            begin_frame(mgmt_subs[2'(i)]);
            add_element(filler_id(), 8'd2);
            add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, ds_vals[i]);
            send_frame(frame_buf.size());
            begin_frame(mgmt_subs[2'(i + 1)]);
            add_channel_element(mfce_pkg::EID_HT_INFO, 8'd22, ht_vals[i]);
            send_frame(frame_buf.size());
        end
    endtask

    // A zero-length DS or HT element takes the next element's id as its channel.
    task automatic test_zero_length_element();
        begin_frame(mfce_pkg::SUB_PROBE_REQ);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd0, 8'd0);
        add_element(8'd7, 8'd1);
        send_frame(frame_buf.size());
        begin_frame(mfce_pkg::SUB_ASSOC_REQ);
        add_channel_element(mfce_pkg::EID_HT_INFO, 8'd0, 8'd0);
        add_element(8'd100, 8'd0);
        send_frame(frame_buf.size());
        begin_frame(mfce_pkg::SUB_BEACON);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd0, 8'd0);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, 8'd9);
        send_frame(frame_buf.size());
    endtask

    // Frames that stop in the header, at an id, a length, a body or the channel.
    task automatic test_early_end();
        int unsigned cuts[5] = '{10, 24, 25, 26, 27};
        for (int i = 0; i < 5; i++)
        begin
            begin_frame(mfce_pkg::SUB_PROBE_REQ);
            add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, 8'd6);
            send_frame(cuts[i]);
        end
        begin_frame(mfce_pkg::SUB_PROBE_REQ);
        add_element(filler_id(), 8'd4);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, 8'd6);
        send_frame(27);
    endtask

    // The first DS or HT element decides, and the walk goes past byte 63.
    task automatic test_first_element_decides();
        begin_frame(mfce_pkg::SUB_PROBE_RESP);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, 8'd20);
        add_channel_element(mfce_pkg::EID_HT_INFO, 8'd1, 8'd40);
        send_frame(frame_buf.size());
        begin_frame(mfce_pkg::SUB_ASSOC_REQ);
        add_channel_element(mfce_pkg::EID_HT_INFO, 8'd3, 8'd149);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, 8'd11);
        send_frame(frame_buf.size());
        begin_frame(mfce_pkg::SUB_BEACON);
        repeat (3)
            add_element(filler_id(), 8'd10);
        add_channel_element(mfce_pkg::EID_DS_PARAM, 8'd1, 8'd13);
        send_frame(frame_buf.size());
    endtask

    // The receiver holds off while short frames keep coming, filling the block.
    task automatic test_result_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_cycles <= HOLD_OFF_CYCLES;
        repeat (16)
        begin
            frame_buf = {};
            frame_buf.push_back(8'($urandom_range(0, 255)));
            send_frame(1);
        end
        repeat (4)
            send_random_frame();
    endtask

    // Random frames under one idle and stall mix until the byte budget is used.
    task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned stop_at;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at            = bytes_taken + RANDOM_BYTES;
        while (bytes_taken < stop_at)
            send_random_frame();
    endtask

    // Test sequence, drain and verdict.
    initial
    begin
        int unsigned waited;
        restart_walk();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_control_only();
        test_channel_ranges();
        test_zero_length_element();
        test_early_end();
        test_first_element_decides();
        test_result_hold_off();
        test_random_frames(0, 0);
        test_random_frames(62, 0);
        test_random_frames(0, 62);
        test_random_frames(36, 36);

        // Drain the outstanding reports, then let the pipeline settle.
        frame_valid       <= 1'b0;
        receiver_stall_pct = 0;
        waited             = 0;
        while (channel_reports.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8)
            @(posedge clk);
        if (channel_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", channel_reports.size()));

        $display("Covered %0d frames in %0d bytes: directed cases, a %0d-cycle hold-off, %s",
                 frames_sent, bytes_taken, HOLD_OFF_CYCLES, "four idle/stall mixes.");
        $display("Reports checked: %0d found, %0d no channel, %0d unsupported.",
                 found_seen, missing_seen, unsupp_seen);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
